FILE: hw/rtl/stb_pkg.sv
// Shared types and constants for the software timer slot bank.
// Used by software_timer_slot_bank and its checker; depends on nothing.
package stb_pkg;

    localparam int SLOTS        = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int SLOT_FIELD_W = 4;
    localparam int PERIOD_W     = 32;
    localparam int MASK_W       = 16;
    localparam int SLOT_IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [1:0]             t_func;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [SLOT_IW-1:0]     t_slot_idx;

    localparam t_func FUNC_TICK  = 2'd0;
    localparam t_func FUNC_START = 2'd1;
    localparam t_func FUNC_CLOSE = 2'd2;

    typedef struct packed {
        t_func                   func;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [PERIOD_W-1:0]     period;
        logic                    notify_enable;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] fire_mask;
        logic [MASK_W-1:0] expired_mask;
    } t_out_item;

endpackage

FILE: hw/rtl/software_timer_slot_bank.sv
// Top level of the software timer slot bank: command decode, tick walk over the
// count and limit memories, and the result register. Depends on stb_pkg.

// Bank of stb_pkg::SLOTS timer slots. Each input beat (tick, start or close) yields one
// result beat carrying the fire mask and the expired mask after that command. Start and
// close pass from accept through ST_DONE to the result register. A tick passes through
// ST_WALK first: the counts and limits sit in single-port-read memories with registered
// reads, so the tick walks the slots one per cycle, reading one entry while writing
// back the previous one. The started, notify and expired flags live in flip-flops.
// A new command is taken while the previous result still waits at the output; the
// block then holds its finished result until the output register frees up. The count
// and limit memories need no clearing after reset: a slot is only counted once a start
// has written both of its entries.
module software_timer_slot_bank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stb_pkg::t_out_item  o_out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [stb_pkg::SLOTS-1:0] r_started;
    logic [stb_pkg::SLOTS-1:0] r_notify;
    logic [stb_pkg::SLOTS-1:0] r_expired;
    logic [stb_pkg::SLOTS-1:0] r_fire;
    stb_pkg::t_slot_idx        r_idx;
    logic                      r_out_valid;
    stb_pkg::t_out_item        r_out_data;

    stb_pkg::t_count mem_count [stb_pkg::SLOTS];
    stb_pkg::t_count mem_limit [stb_pkg::SLOTS];
    stb_pkg::t_count r_count_rd;
    stb_pkg::t_count r_limit_rd;

    logic               in_acc;
    logic               in_bank;
    logic               out_free;
    logic               last;
    logic               walk;
    stb_pkg::t_slot_idx slot_idx;
    stb_pkg::t_slot_idx rd_addr;
    stb_pkg::t_count    period_cnt;

    logic               cnt_lt;
    stb_pkg::t_count    cnt_inc;
    stb_pkg::t_count    cnt_new;
    logic               exp_new;

    logic               cnt_we;
    stb_pkg::t_slot_idx cnt_waddr;
    stb_pkg::t_count    cnt_wdata;
    logic               lim_we;

    logic [stb_pkg::SLOTS-1:0] start_fire;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_acc     = i_in_valid && o_in_ready;
    assign in_bank    = ({1'b0, i_in_data.slot} < (stb_pkg::SLOT_FIELD_W + 1)'(stb_pkg::SLOTS));
    assign slot_idx   = stb_pkg::t_slot_idx'(i_in_data.slot);
    assign period_cnt = stb_pkg::t_count'(i_in_data.period);
    assign out_free   = !r_out_valid || i_out_ready;
    assign last       = (r_idx == stb_pkg::t_slot_idx'(stb_pkg::SLOTS - 1));
    assign walk       = (r_state == ST_WALK);

    // Read slot 0 on the accept edge so its data is ready in the first walk cycle.
    assign rd_addr = (r_state == ST_IDLE) ? '0 :
                     (last ? r_idx : r_idx + stb_pkg::t_slot_idx'(1));

    // Count up only below the limit; the incremented value hits the limit exactly.
    assign cnt_lt  = (r_count_rd < r_limit_rd);
    assign cnt_inc = r_count_rd + stb_pkg::t_count'(1);
    assign cnt_new = cnt_lt ? cnt_inc : r_count_rd;
    assign exp_new = !cnt_lt || (cnt_inc == r_limit_rd);

    // A start with a zero period and notify enabled fires its own slot at once.
    always_comb begin
        start_fire = '0;
        if (in_bank && (i_in_data.func == stb_pkg::FUNC_START)) begin
            start_fire[slot_idx] = (period_cnt == '0) && i_in_data.notify_enable;
        end
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = slot_idx;
        cnt_wdata = '0;
        lim_we    = 1'b0;
        if (in_acc && in_bank) begin
            unique case (i_in_data.func)
                stb_pkg::FUNC_START: begin
                    cnt_we = 1'b1;
                    lim_we = 1'b1;
                end
                stb_pkg::FUNC_CLOSE: begin
                    cnt_we = 1'b1;
                end
                default: begin
                    cnt_we = 1'b0;
                end
            endcase
        end else if (walk && r_started[r_idx]) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_idx;
            cnt_wdata = cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_count[cnt_waddr] <= cnt_wdata;
        end
        if (lim_we) begin
            mem_limit[slot_idx] <= period_cnt;
        end
        r_count_rd <= mem_count[rd_addr];
        r_limit_rd <= mem_limit[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.func == stb_pkg::FUNC_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= '0;
            r_notify    <= '0;
            r_expired   <= '0;
            r_fire      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_fire <= start_fire;
                r_idx  <= '0;
                if (in_bank) begin
                    unique case (i_in_data.func)
                        stb_pkg::FUNC_START: begin
                            r_started[slot_idx] <= 1'b1;
                            r_notify[slot_idx]  <= i_in_data.notify_enable;
                            r_expired[slot_idx] <= (period_cnt == '0);
                        end
                        stb_pkg::FUNC_CLOSE: begin
                            r_started[slot_idx] <= 1'b0;
                            r_notify[slot_idx]  <= 1'b0;
                            r_expired[slot_idx] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            if (walk) begin
                if (r_started[r_idx]) begin
                    r_expired[r_idx] <= exp_new;
                    r_fire[r_idx]    <= exp_new && r_notify[r_idx];
                end
                if (!last) begin
                    r_idx <= r_idx + stb_pkg::t_slot_idx'(1);
                end
            end
            // Load the result beat when the output register is free, else drop valid on take.
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data.fire_mask    <= stb_pkg::MASK_W'(r_fire);
            r_out_data.expired_mask <= stb_pkg::MASK_W'(r_expired);
        end
    end

endmodule

FILE: hw/rtl/stb_check.sv
// Port-level checker for software_timer_slot_bank, bound to the top level below.
// Depends on stb_pkg for the beat types.
module stb_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input stb_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input stb_pkg::t_out_item  o_out_data
);

    // Result valid holds until the beat is taken.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result valid dropped before the beat was taken");

    // A stalled result beat keeps its payload.
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A slot only fires while it is expired.
    a_fire_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.fire_mask & ~o_out_data.expired_mask) == '0))
        else $error("fire bit set for a slot that is not expired");

    // One command at a time: ready drops after an accepted beat.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid high right after reset");

endmodule

bind software_timer_slot_bank stb_check u_stb_check (.*);
